/* hdl/mtsq_pkg.sv */
// Shared constants, codes and control types of the median threshold sensor qualifier.
`default_nettype none

package mtsq_pkg;

  localparam int SampleW        = 10;
  localparam int ChanFieldW     = 3;
  localparam int CfgW           = 50;
  localparam int CfgIdxW        = 2;
  localparam int DefLineWindow  = 5;
  localparam int DefFlameWindow = 5;
  localparam int DefChannels    = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAME_LIMITS = 2'd0,
    CFG_BLACK_THRESH = 2'd1,
    CFG_WHITE_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_LOAD,
    ST_PICK,
    ST_CMP,
    ST_DECIDE,
    ST_TH_A,
    ST_TH_B,
    ST_OUT
  } state_e;

  // Operand routing of the shared comparator
  typedef enum logic [1:0] {
    SEL_RANK,
    SEL_MED_WHITE,
    SEL_THR_MED
  } cmp_sel_e;

  typedef struct packed {
    logic     busy;
    logic     wr_en;
    logic     shift_en;
    logic     pick;
    logic     count;
    logic     rotate;
    logic     zero;
    logic     det_ld;
    logic     det_val;
    logic     flag_ld;
    logic     out_load;
    cmp_sel_e sel;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic ch_ok;
    logic kind;
    logic found;
    logic lt;
    logic flag_cur;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/mtsq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mtsq_ram #(
  parameter int Width = 10,
  parameter int Depth = 50
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/mtsq_rank.sv */
// Shared comparator with below/equal rank counters and median test.
`default_nettype none

module mtsq_rank #(
  parameter int CntW = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mtsq_pkg::SampleW-1:0] a_i,
  input  logic [mtsq_pkg::SampleW-1:0] b_i,
  input  logic                        clr_i,
  input  logic                        acc_i,
  input  logic [CntW-1:0]             target_i,
  output logic                        lt_o,
  output logic                        found_o
);
  import mtsq_pkg::*;

  logic [CntW-1:0] below_q, below_d;
  logic [CntW-1:0] same_q, same_d;
  logic            eq;
  logic [CntW:0]   upper;

  assign lt_o = a_i < b_i;
  assign eq   = a_i == b_i;

  always_comb begin
    below_d = below_q;
    same_d  = same_q;
    if (clr_i) begin
      below_d = '0;
      same_d  = '0;
    end else if (acc_i) begin
      if (lt_o) begin
        below_d = below_q + CntW'(1);
      end else if (eq) begin
        same_d = same_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q <= '0;
      same_q  <= '0;
    end else begin
      below_q <= below_d;
      same_q  <= same_d;
    end
  end

  // candidate is the median when its rank span covers the target rank
  assign upper   = {1'b0, below_q} + {1'b0, same_q};
  assign found_o = (below_q <= target_i) && ({1'b0, target_i} < upper);

endmodule

`default_nettype wire

/* hdl/mtsq_ctrl.sv */
// Sequencer: write, window load, rank passes, threshold checks and result hand-off.
`default_nettype none

module mtsq_ctrl #(
  parameter int CntW = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtsq_pkg::sts_t       sts_i,
  input  logic [CntW-1:0]      win_n_i,
  output mtsq_pkg::ctl_t       ctl_o,
  output logic [CntW-1:0]      rd_idx_o
);
  import mtsq_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] last;

  assign last     = win_n_i - CntW'(1);
  assign rd_idx_o = k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      i_q     <= i_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    j_d       = j_q;
    i_d       = i_q;
    ctl_o     = '0;
    ctl_o.sel = SEL_RANK;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.accept) begin
          if (sts_i.ch_ok) begin
            state_d = ST_WRITE;
          end else begin
            // unknown channel: zero result, no state touched
            ctl_o.zero    = 1'b1;
            ctl_o.det_ld  = 1'b1;
            ctl_o.det_val = 1'b0;
            state_d       = ST_OUT;
          end
        end
      end
      ST_WRITE: begin
        ctl_o.busy  = 1'b1;
        ctl_o.wr_en = 1'b1;
        k_d         = '0;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        ctl_o.busy     = 1'b1;
        ctl_o.shift_en = (k_q != '0);
        if (k_q == win_n_i) begin
          i_d     = '0;
          state_d = ST_PICK;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      ST_PICK: begin
        ctl_o.busy = 1'b1;
        ctl_o.pick = 1'b1;
        j_d        = '0;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        ctl_o.busy  = 1'b1;
        ctl_o.count = 1'b1;
        if (j_q == last) begin
          state_d = ST_DECIDE;
        end else begin
          j_d = j_q + CntW'(1);
        end
      end
      ST_DECIDE: begin
        ctl_o.busy = 1'b1;
        if (sts_i.found || (i_q == last)) begin
          state_d = ST_TH_A;
        end else begin
          ctl_o.rotate = 1'b1;
          i_d          = i_q + CntW'(1);
          state_d      = ST_PICK;
        end
      end
      ST_TH_A: begin
        ctl_o.busy = 1'b1;
        if (sts_i.kind) begin
          ctl_o.sel     = SEL_THR_MED;
          ctl_o.det_ld  = 1'b1;
          ctl_o.det_val = sts_i.lt;
          state_d       = ST_OUT;
        end else begin
          ctl_o.sel = SEL_MED_WHITE;
          if (sts_i.lt) begin
            ctl_o.det_ld  = 1'b1;
            ctl_o.det_val = 1'b1;
            ctl_o.flag_ld = 1'b1;
            state_d       = ST_OUT;
          end else begin
            state_d = ST_TH_B;
          end
        end
      end
      ST_TH_B: begin
        ctl_o.busy    = 1'b1;
        ctl_o.sel     = SEL_THR_MED;
        ctl_o.det_ld  = 1'b1;
        ctl_o.flag_ld = 1'b1;
        ctl_o.det_val = sts_i.lt ? 1'b0 : sts_i.flag_cur;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        ctl_o.busy = 1'b1;
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/median_threshold_sensor_qualifier.sv */
// Top level: median filtered line/flame sensor qualifier with per-channel line hysteresis.
// From accept to result beat: sample write, window load, one rank pass per candidate until
// the median is found, one or two threshold checks, then output hand-off. An unknown channel
// goes straight to the output hand-off.
// One item at a time: the next beat is taken the cycle after the result is registered.
// Reset: flame limits all ones; control, thresholds, write positions, line flags, valid bits cleared.
`default_nettype none

module median_threshold_sensor_qualifier #(
  parameter int LINE_WINDOW  = mtsq_pkg::DefLineWindow,
  parameter int FLAME_WINDOW = mtsq_pkg::DefFlameWindow,
  parameter int CHANNELS     = mtsq_pkg::DefChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mtsq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mtsq_pkg::CfgW-1:0]       cfg_data_i,
  // sample input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [mtsq_pkg::ChanFieldW-1:0] channel_i,
  input  logic [mtsq_pkg::SampleW-1:0]    sample_i,
  // result output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           bank_o,
  output logic [mtsq_pkg::ChanFieldW-1:0] lane_o,
  output logic [mtsq_pkg::SampleW-1:0]    filtered_o,
  output logic                           detected_o
);
  import mtsq_pkg::*;

  // Window storage: all line windows first, then all flame windows, in one RAM.
  localparam int MaxWin = (LINE_WINDOW > FLAME_WINDOW) ? LINE_WINDOW : FLAME_WINDOW;
  localparam int PosW   = (MaxWin > 1) ? $clog2(MaxWin) : 1;
  localparam int CntW   = $clog2(MaxWin + 1);
  localparam int Depth  = CHANNELS * (LINE_WINDOW + FLAME_WINDOW);
  localparam int AddrW  = $clog2(Depth);
  localparam int ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ctl_t ctl;
  sts_t sts;

  // configuration registers
  logic [CfgW-1:0]    flame_q;
  logic [CfgW-1:0]    black_q;
  logic [SampleW-1:0] white_q;

  // latched input beat
  logic                  kind_q;
  logic [ChanFieldW-1:0] ch_q;
  logic [SampleW-1:0]    sample_q;
  logic [ChW-1:0]        ch_idx;

  // per-channel state
  logic [PosW-1:0]     lpos_q [CHANNELS];
  logic [PosW-1:0]     fpos_q [CHANNELS];
  logic [CHANNELS-1:0] lflag_q;
  logic [Depth-1:0]    vld_q;

  // window copy, candidate and comparator routing
  logic [SampleW-1:0] win_q [MaxWin];
  logic [SampleW-1:0] win_d [MaxWin];
  logic [SampleW-1:0] cand_q;
  logic [SampleW-1:0] shift_in;
  logic [SampleW-1:0] cmp_a, cmp_b;
  logic [SampleW-1:0] limit_cur, black_cur;
  logic               det_q;
  logic               lt;
  logic               found;

  logic [CntW-1:0]    win_n;
  logic [CntW-1:0]    rd_idx;
  logic [PosW-1:0]    pos_cur, pos_nx;
  logic [AddrW-1:0]   base_a, wr_addr, rd_addr;
  logic [SampleW-1:0] rdata;
  logic               rd_vld_q;

  // output register
  logic                  out_valid_q;
  logic                  bank_q;
  logic [ChanFieldW-1:0] lane_q;
  logic [SampleW-1:0]    filt_q;
  logic                  det_out_q;

  logic in_accept;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; writes beyond the register list are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flame_q <= '1;
      black_q <= '0;
      white_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FLAME_LIMITS: flame_q <= cfg_data_i;
        CFG_BLACK_THRESH: black_q <= cfg_data_i;
        CFG_WHITE_THRESH: white_q <= cfg_data_i[SampleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input beat: taken only while the sequencer is idle.
  // ---------------------------------------------------------------------------
  assign in_stall_o = ctl.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= kind_i;
      ch_q     <= channel_i;
      sample_q <= sample_i;
    end
  end

  assign ch_idx = ch_q[ChW-1:0];
  assign win_n  = kind_q ? CntW'(FLAME_WINDOW) : CntW'(LINE_WINDOW);

  // ---------------------------------------------------------------------------
  // Window addressing and per-channel circular write position.
  // ---------------------------------------------------------------------------
  assign pos_cur = kind_q ? fpos_q[ch_idx] : lpos_q[ch_idx];
  assign pos_nx  = (pos_cur == PosW'(win_n - CntW'(1))) ? '0 : pos_cur + PosW'(1);

  assign base_a  = kind_q ? AddrW'(CHANNELS * LINE_WINDOW)
                            + AddrW'(ch_idx) * AddrW'(FLAME_WINDOW)
                          : AddrW'(ch_idx) * AddrW'(LINE_WINDOW);
  assign wr_addr = base_a + AddrW'(pos_cur);
  assign rd_addr = base_a + AddrW'(rd_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lpos_q[c] <= '0;
        fpos_q[c] <= '0;
      end
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (ctl.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
        if (kind_q) begin
          fpos_q[ch_idx] <= pos_nx;
        end else begin
          lpos_q[ch_idx] <= pos_nx;
        end
      end
    end
  end

  mtsq_ram #(
    .Width (SampleW),
    .Depth (Depth)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (sample_q),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Window copy: a circular shift line of W active taps. During load the RAM
  // data enters at the top tap (never-written entries read as zero); during
  // ranking tap 0 wraps round so every value passes the comparator in turn.
  // ---------------------------------------------------------------------------
  assign shift_in = ctl.shift_en ? (rdata & {SampleW{rd_vld_q}}) : win_q[0];

  always_comb begin
    for (int k = 0; k < MaxWin; k++) begin
      if (CntW'(k) == win_n - CntW'(1)) begin
        win_d[k] = shift_in;
      end else begin
        win_d[k] = win_q[(k < MaxWin - 1) ? k + 1 : k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.shift_en || ctl.count || ctl.rotate) begin
      win_q <= win_d;
    end
    if (ctl.zero) begin
      cand_q <= '0;
    end else if (ctl.pick) begin
      cand_q <= win_q[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared comparator: rank counting, then the threshold checks on the median.
  // ---------------------------------------------------------------------------
  assign limit_cur = flame_q[SampleW * ch_q +: SampleW];
  assign black_cur = black_q[SampleW * ch_q +: SampleW];

  always_comb begin
    case (ctl.sel)
      SEL_MED_WHITE: begin
        cmp_a = cand_q;
        cmp_b = white_q;
      end
      SEL_THR_MED: begin
        cmp_a = kind_q ? limit_cur : black_cur;
        cmp_b = cand_q;
      end
      default: begin
        cmp_a = win_q[0];
        cmp_b = cand_q;
      end
    endcase
  end

  mtsq_rank #(
    .CntW (CntW)
  ) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .clr_i    (ctl.pick),
    .acc_i    (ctl.count),
    .target_i (win_n >> 1),
    .lt_o     (lt),
    .found_o  (found)
  );

  // line hysteresis flag and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lflag_q <= '0;
      det_q   <= 1'b0;
    end else begin
      if (ctl.det_ld) begin
        det_q <= ctl.det_val;
      end
      if (ctl.flag_ld) begin
        lflag_q[ch_idx] <= ctl.det_val;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign sts.accept   = in_accept;
  assign sts.ch_ok    = channel_i < ChanFieldW'(CHANNELS);
  assign sts.kind     = kind_q;
  assign sts.found    = found;
  assign sts.lt       = lt;
  assign sts.flag_cur = lflag_q[ch_idx];
  assign sts.out_free = !out_valid_q || !out_stall_i;

  mtsq_ctrl #(
    .CntW (CntW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sts_i    (sts),
    .win_n_i  (win_n),
    .ctl_o    (ctl),
    .rd_idx_o (rd_idx)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the result beat until the sink takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      bank_q    <= kind_q;
      lane_q    <= ch_q;
      filt_q    <= cand_q;
      det_out_q <= det_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bank_o      = bank_q;
  assign lane_o      = lane_q;
  assign filtered_o  = filt_q;
  assign detected_o  = det_out_q;

`ifndef SYNTHESIS
  // an accepted beat always makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is still being processed");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("held result overwritten");

  // an unknown channel yields a zero median and no detection
  a_bad_lane_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lane_o >= ChanFieldW'(CHANNELS)) |-> (filtered_o == '0) && !detected_o)
    else $error("unknown channel produced a non-zero result");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the median threshold sensor qualifier: directed edges, random phases.
`timescale 1ns / 100ps

module tb;

  import mtsq_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int LineWin       = DefLineWindow;
  localparam int FlameWin      = DefFlameWindow;
  localparam int NumChan       = DefChannels;
  localparam int LongHold      = 200;    // cycles the receiver holds off in the pressure test
  localparam int SettleCycles  = 60;     // idle cycles after the final drain before the verdict
  localparam int TimeoutCycles = 400000;

  typedef logic [SampleW-1:0] sample_t;

  // One result beat, in port order
  typedef struct packed {
    logic                  bank;
    logic [ChanFieldW-1:0] lane;
    sample_t               filtered;
    logic                  detected;
  } qual_result_t;

  // ------------------------------------------------------------------
  // Clock, reset and DUT-facing signals; every input known from time 0
  // ------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgW-1:0]       cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  kind      = 1'b0;
  logic [ChanFieldW-1:0] chan      = '0;
  sample_t               smp       = '0;
  logic                  out_stall = 1'b0;

  logic                  cfg_ready;
  logic                  in_stall;
  logic                  out_valid;
  logic                  bank;
  logic [ChanFieldW-1:0] lane;
  sample_t               filtered;
  logic                  detected;

  always #(ClkPeriod / 2) clk = ~clk;

  median_threshold_sensor_qualifier i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .channel_i   (chan),
    .sample_i    (smp),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .bank_o      (bank),
    .lane_o      (lane),
    .filtered_o  (filtered),
    .detected_o  (detected)
  );

  // ------------------------------------------------------------------
  // Shadow of the qualifier: config registers, windows, positions, flags
  // ------------------------------------------------------------------
  logic [CfgW-1:0] flame_limit_regs;
  logic [CfgW-1:0] black_thresh_regs;
  sample_t         white_thresh;
  sample_t         line_hist  [NumChan][LineWin];
  sample_t         flame_hist [NumChan][FlameWin];
  int              line_pos   [NumChan];
  int              flame_pos  [NumChan];
  logic            line_present [NumChan];

  qual_result_t    pending_results[$];   // expected beats, oldest first
  int              errors        = 0;
  int              cycle_count   = 0;
  int              send_idle_pct = 0;
  int              stall_pct     = 0;
  int              hold_trigger  = 0;      // bump to request one long receiver hold-off
  int              hold_seen     = 0;
  int              hold_left     = 0;

  // Value of rank W/2 in ascending order: true median for odd W, upper middle for even W
  function automatic sample_t rank_middle(input sample_t vals[$]);
    int      i;
    int      j;
    sample_t t;
    for (i = 1; i < vals.size(); i++) begin
      t = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > t) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = t;
    end
    return vals[vals.size() / 2];
  endfunction

  // Advance the shadow by one accepted sample and return the beat it must produce
  function automatic qual_result_t predict_qualifier(input logic k,
                                                     input logic [ChanFieldW-1:0] c,
                                                     input sample_t s);
    qual_result_t r;
    sample_t      win[$];
    sample_t      med;
    int           ch;
    ch         = int'(c);
    r.bank     = k;
    r.lane     = c;
    r.filtered = '0;
    r.detected = 1'b0;
    // unknown channels leave every window and flag alone
    if (ch < NumChan) begin
      if (k) begin
        flame_hist[ch][flame_pos[ch]] = s;
        flame_pos[ch] = (flame_pos[ch] + 1) % FlameWin;
        for (int i = 0; i < FlameWin; i++) win.push_back(flame_hist[ch][i]);
        med = rank_middle(win);
        // strictly above the limit; equal means no flame
        r.detected = (med > flame_limit_regs[ch*SampleW +: SampleW]);
      end else begin
        line_hist[ch][line_pos[ch]] = s;
        line_pos[ch] = (line_pos[ch] + 1) % LineWin;
        for (int i = 0; i < LineWin; i++) win.push_back(line_hist[ch][i]);
        med = rank_middle(win);
        // hysteresis: set below white, clear above black, hold on or between
        if (med < white_thresh) begin
          line_present[ch] = 1'b1;
        end else if (med > black_thresh_regs[ch*SampleW +: SampleW]) begin
          line_present[ch] = 1'b0;
        end
        r.detected = line_present[ch];
      end
      r.filtered = med;
    end
    return r;
  endfunction

  function automatic logic [CfgW-1:0] rand_cfg();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CfgW-1:0];
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  // Write one register; returns at a rising edge with the write channel dropping
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_FLAME_LIMITS: flame_limit_regs  = data;
      CFG_BLACK_THRESH: black_thresh_regs = data;
      CFG_WHITE_THRESH: white_thresh      = data[SampleW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one sample beat; called and returning at a rising edge.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic send_sample(input logic k, input logic [ChanFieldW-1:0] c, input sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    chan     <= c;
    smp      <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_qualifier(k, c, s));
  endtask

  // Mostly valid channels; samples biased towards the extremes and the live thresholds
  task automatic send_random_item();
    logic                  k;
    logic [ChanFieldW-1:0] c;
    sample_t               s;
    int                    ch;
    int                    pick;
    int                    base;
    k    = 1'($urandom_range(0, 1));
    c    = ($urandom_range(0, 7) == 0) ? ChanFieldW'($urandom_range(NumChan, 7))
                                       : ChanFieldW'($urandom_range(0, NumChan - 1));
    ch   = int'(c);
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      s = '0;
    end else if (pick == 1) begin
      s = '1;
    end else if (pick <= 3 && ch < NumChan) begin
      if (k) begin
        base = int'(flame_limit_regs[ch*SampleW +: SampleW]);
      end else if (pick == 2) begin
        base = int'(white_thresh);
      end else begin
        base = int'(black_thresh_regs[ch*SampleW +: SampleW]);
      end
      base = base + int'($urandom_range(0, 6)) - 3;
      if (base < 0) base = 0;
      if (base > 1023) base = 1023;
      s = sample_t'(base);
    end else begin
      s = sample_t'($urandom_range(0, 1023));
    end
    send_sample(k, c, s);
  endtask

  // Drop valid and hold the sender until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    repeat (count) send_random_item();
    drain_results();
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset values: flame limit all ones never trips, line thresholds at zero hold the flag
  task automatic test_reset_defaults();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_sample(1'b1, 3'd3, 10'd1023);
    send_sample(1'b0, 3'd3, 10'd0);
    drain_results();
  endtask

  // Medians landing on, below and above each threshold; unknown channels echo only
  task automatic test_threshold_edges();
    write_reg(CFG_FLAME_LIMITS, {10'd600, 10'd1023, 10'd512, 10'd0, 10'd100});
    write_reg(CFG_BLACK_THRESH, {5{10'd700}});
    // upper bits of the white write must be dropped
    write_reg(CFG_WHITE_THRESH, {40'hABCDEF0123, 10'd300});
    // line ch0: set below white, hold on white, hold on black, clear above black
    send_sample(1'b0, 3'd0, 10'd300);
    send_sample(1'b0, 3'd0, 10'd300);
    send_sample(1'b0, 3'd0, 10'd300);
    send_sample(1'b0, 3'd0, 10'd700);
    send_sample(1'b0, 3'd0, 10'd700);
    send_sample(1'b0, 3'd0, 10'd700);
    send_sample(1'b0, 3'd0, 10'd1023);
    send_sample(1'b0, 3'd0, 10'd1023);
    send_sample(1'b0, 3'd0, 10'd1023);
    // flame ch2: median equal to the limit, then above it
    send_sample(1'b1, 3'd2, 10'd512);
    send_sample(1'b1, 3'd2, 10'd512);
    send_sample(1'b1, 3'd2, 10'd512);
    send_sample(1'b1, 3'd2, 10'd1023);
    send_sample(1'b1, 3'd2, 10'd1023);
    send_sample(1'b1, 3'd2, 10'd1023);
    // flame ch1 limit zero: zero median is not above it, one is
    send_sample(1'b1, 3'd1, 10'd0);
    send_sample(1'b1, 3'd1, 10'd1);
    send_sample(1'b1, 3'd1, 10'd1);
    send_sample(1'b1, 3'd1, 10'd1);
    // last channel of each bank
    send_sample(1'b0, 3'd4, 10'd0);
    send_sample(1'b1, 3'd4, 10'd1023);
    // channels past the last one
    send_sample(1'b1, 3'd5, 10'd1023);
    send_sample(1'b0, 3'd6, 10'd512);
    send_sample(1'b1, 3'd7, 10'd0);
    drain_results();
  endtask

  task automatic test_random_no_idle();
    write_reg(CFG_FLAME_LIMITS, rand_cfg());
    write_reg(CFG_BLACK_THRESH, rand_cfg());
    write_reg(CFG_WHITE_THRESH, rand_cfg());
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_phase(300);
  endtask

  // Extremes: every flame limit zero, black all ones, white at the top
  task automatic test_random_sender_idle();
    write_reg(CFG_FLAME_LIMITS, '0);
    write_reg(CFG_BLACK_THRESH, '1);
    write_reg(CFG_WHITE_THRESH, '1);
    send_idle_pct = 75;
    stall_pct     = 0;
    run_random_phase(250);
  endtask

  // Opposite extremes: limits all ones, thresholds zero
  task automatic test_random_receiver_stall();
    write_reg(CFG_FLAME_LIMITS, '1);
    write_reg(CFG_BLACK_THRESH, '0);
    write_reg(CFG_WHITE_THRESH, '0);
    send_idle_pct = 0;
    stall_pct     = 75;
    run_random_phase(250);
  endtask

  task automatic test_random_both_idle();
    write_reg(CFG_FLAME_LIMITS, rand_cfg());
    write_reg(CFG_BLACK_THRESH, rand_cfg());
    write_reg(CFG_WHITE_THRESH, 50'($urandom_range(0, 1023)));
    send_idle_pct = 12;
    stall_pct     = 12;
    run_random_phase(250);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block backs up and stalls
  // its input; drop valid until all has drained, then run a random phase with idles and stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_trigger++;
    repeat (20) send_random_item();
    drain_results();
    send_idle_pct = 30;
    stall_pct     = 30;
    run_random_phase(20);
  endtask

  // ------------------------------------------------------------------
  // Receiver: random stall, or a long counted hold-off on request
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Result checker: compare each accepted beat with the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    qual_result_t want;
    qual_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {bank, lane, filtered, detected};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: bank %0d lane %0d filtered %0d detected %0d",
                 $time, got.bank, got.lane, got.filtered, got.detected);
      end else begin
        want = pending_results.pop_front();
        if (got.bank !== want.bank || got.lane !== want.lane ||
            got.filtered !== want.filtered || got.detected !== want.detected) begin
          errors++;
          $display("%0t: mismatch: expected bank %0d lane %0d filtered %0d detected %0d",
                   $time, want.bank, want.lane, want.filtered, want.detected);
          $display("%0t:           actual   bank %0d lane %0d filtered %0d detected %0d",
                   $time, got.bank, got.lane, got.filtered, got.detected);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TimeoutCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    // shadow starts from the reset state
    flame_limit_regs  = '1;
    black_thresh_regs = '0;
    white_thresh      = '0;
    for (int c = 0; c < NumChan; c++) begin
      line_pos[c]     = 0;
      flame_pos[c]    = 0;
      line_present[c] = 1'b0;
      for (int i = 0; i < LineWin; i++) line_hist[c][i] = '0;
      for (int i = 0; i < FlameWin; i++) flame_hist[c][i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_edges();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
